>>> src/psgenc_pkg.sv
// Shared types, constants and the semitone period table for the PSG command encoder.
// No dependencies; imported by every module of the block.
package psgenc_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    FUNC_NOTE    = 2'd0,
    FUNC_VOLUME  = 2'd1,
    FUNC_NOISE   = 2'd2,
    FUNC_ALL_OFF = 2'd3
  } psgenc_func_t;

  localparam int unsigned MAX_BYTES   = 4;
  localparam int unsigned BIDX_W      = $clog2(MAX_BYTES);
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned PERIOD_W    = 10;

  localparam logic [1:0] NOISE_VOICE  = 2'd3;
  localparam logic [6:0] OCT_RECIP    = 7'd43;  // 43/512 ~ 1/12, exact for notes 0..127
  localparam logic [3:0] OCT_BASE     = 4'd3;

  localparam logic [7:0] OFF_VOICE0   = 8'b1001_1111;
  localparam logic [7:0] OFF_VOICE1   = 8'b1011_1111;
  localparam logic [7:0] OFF_VOICE2   = 8'b1101_1111;
  localparam logic [7:0] OFF_VOICE3   = 8'b1111_1111;

  // Request as accepted on the input side
  typedef struct packed {
    logic [1:0] func;
    logic [1:0] channel;
    logic [6:0] note;
    logic [3:0] volume;
    logic       noise_mode;
    logic [1:0] shift_rate;
  } psgenc_req_t;

  // One command byte on the result side
  typedef struct packed {
    logic [7:0] command_byte;
    logic       last;
  } psgenc_res_t;

  // Decoded run: up to four bytes and the index of the final one
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BIDX_W-1:0]         last_idx;
  } psgenc_desc_t;

  // Top-octave periods, one per semitone
  function automatic logic [PERIOD_W-1:0] psgenc_semitone(input logic [3:0] idx);
    logic [PERIOD_W-1:0] p;
    unique case (idx)
      4'd0:    p = 10'd978;
      4'd1:    p = 10'd924;
      4'd2:    p = 10'd872;
      4'd3:    p = 10'd823;
      4'd4:    p = 10'd777;
      4'd5:    p = 10'd733;
      4'd6:    p = 10'd692;
      4'd7:    p = 10'd653;
      4'd8:    p = 10'd616;
      4'd9:    p = 10'd582;
      4'd10:   p = 10'd549;
      4'd11:   p = 10'd518;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Attenuation latch: 15 - vol is the 4-bit complement
  function automatic logic [7:0] psgenc_atten(input logic [1:0] voice, input logic [3:0] vol);
    return {1'b1, voice, 1'b1, ~vol};
  endfunction

endpackage

>>> src/psgenc_front.sv
// Front end: classifies a request and builds its byte run.
// Depends on psgenc_pkg.
module psgenc_front
  import psgenc_pkg::*;
(
  input  psgenc_req_t  req,
  output psgenc_desc_t desc
);

  logic [12:0]         prod;
  logic [3:0]          octave;
  logic [6:0]          oct12;
  logic [6:0]          rem7;
  logic [2:0]          shift;
  logic [PERIOD_W-1:0] period;

  // octave = note / 12 via reciprocal multiply
  assign prod   = 13'(req.note) * 13'(OCT_RECIP);
  assign octave = prod[12:9];
  assign oct12  = {octave, 3'b000} + {1'b0, octave, 2'b00};
  assign rem7   = req.note - oct12;
  // low notes clamp to no shift
  assign shift  = (octave > OCT_BASE) ? 3'(octave - OCT_BASE) : 3'd0;
  assign period = psgenc_semitone(rem7[3:0]) >> shift;

  always_comb begin
    desc = '0;
    unique case (psgenc_func_t'(req.func))
      FUNC_NOTE: begin
        desc.bytes[0] = psgenc_atten(req.channel, req.volume);
        desc.bytes[1] = {1'b1, req.channel, 1'b0, period[3:0]};
        desc.bytes[2] = {2'b00, period[9:4]};
        desc.last_idx = BIDX_W'(2);
      end
      FUNC_VOLUME: begin
        desc.bytes[0] = psgenc_atten(req.channel, req.volume);
        desc.last_idx = BIDX_W'(0);
      end
      FUNC_NOISE: begin
        desc.bytes[0] = {3'b111, 2'b00, req.noise_mode, ~req.shift_rate};
        desc.bytes[1] = psgenc_atten(NOISE_VOICE, req.volume);
        desc.last_idx = BIDX_W'(1);
      end
      FUNC_ALL_OFF: begin
        desc.bytes[0] = OFF_VOICE0;
        desc.bytes[1] = OFF_VOICE1;
        desc.bytes[2] = OFF_VOICE2;
        desc.bytes[3] = OFF_VOICE3;
        desc.last_idx = BIDX_W'(3);
      end
      default: desc = '0;
    endcase
  end

endmodule

>>> src/psgenc_queue.sv
// Short descriptor queue between front and back end.
// Depends on psgenc_pkg.
module psgenc_queue
  import psgenc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  psgenc_desc_t wr_desc,
  input  logic         rd,
  output logic         q_full,
  output logic         q_valid,
  output psgenc_desc_t head
);

  psgenc_desc_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                      do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_wr ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (cnt_r == '0 && !q_valid))
    else $error("queue not empty after reset");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a write");

endmodule

>>> src/psgenc_back.sv
// Back end: walks head run into out_res, one byte a cycle unless stalled.
// Depends on psgenc_pkg.
module psgenc_back
  import psgenc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  psgenc_desc_t head,
  output logic         q_rd,
  input  logic         pop,
  output logic         empty,
  output psgenc_res_t  out_res
);

  logic [BIDX_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  psgenc_res_t       out_r;
  logic              out_load, emit, is_last;

  assign out_load = !out_valid_r || pop;
  assign emit     = q_valid && out_load;
  assign is_last  = (idx_r == head.last_idx);
  assign q_rd     = emit && is_last;
  assign empty    = !out_valid_r;
  assign out_res  = out_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      idx_nxt       = is_last ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.command_byte <= head.bytes[idx_r];
      out_r.last         <= is_last;
    end
  end

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> idx_r <= head.last_idx)
    else $error("byte index past end of run");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |=> idx_r == '0)
    else $error("byte index not cleared after run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_res)))
    else $error("waiting command byte changed before pop");

endmodule

>>> src/psg_note_command_encoder_core.sv
// Top level of the PSG command encoder: request queue in, command-byte queue out.
// Depends on psgenc_pkg, psgenc_front, psgenc_queue and psgenc_back.
//
// An accepted request is stored in the run queue; its bytes then pass through out_res.
// Throughput: one byte per cycle out while out_res is empty or popped; a request
// holds the back end until its bytes are out (note 3, volume 1, noise 2, all off 4);
// the two-entry run queue accepts one request per cycle while it has room.
// Reset (synchronous, rst_n low): empties the run queue, clears the byte index and the
// output valid; no other state.
module psg_note_command_encoder_core
  import psgenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        push,
  output logic        full,
  input  psgenc_req_t in_req,
  // command-byte side
  output logic        empty,
  input  logic        pop,
  output psgenc_res_t out_res
);

  psgenc_desc_t desc;
  psgenc_desc_t head;
  logic         q_full, q_valid, q_rd;

  // Front end: purely combinational decode, written straight into the queue
  psgenc_front u_front (
    .req  (in_req),
    .desc (desc)
  );

  // Run queue decouples decode from byte sequencing
  psgenc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (push),
    .wr_desc (desc),
    .rd      (q_rd),
    .q_full  (q_full),
    .q_valid (q_valid),
    .head    (head)
  );

  // Back end: one byte per cycle into the output register while it is empty or
  // popped; the head run is released on its last byte, so the next follows without a gap
  psgenc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .out_res (out_res)
  );

  assign full = q_full;

endmodule
